// File: hdl/mtsm_pkg.sv
// Package for the multi-tone sine mixer: payload structs, register indexes,
// parameter defaults and the quarter-wave sine table entry function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtsm_pkg;

  localparam int unsigned MAX_TONES_DEF       = 4;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned PHASE_BITS_DEF      = 32;

  localparam int unsigned NUM_STEP_REGS = 4;
  localparam int unsigned INDEX_W       = 24;
  localparam int unsigned STEP_W        = 32;
  localparam int unsigned GAIN_W        = 16;
  localparam int unsigned COUNT_W       = 3;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(32768);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TONE_COUNT  = 3'd0,
    REG_TONE_STEP_0 = 3'd1,
    REG_TONE_STEP_1 = 3'd2,
    REG_TONE_STEP_2 = 3'd3,
    REG_TONE_STEP_3 = 3'd4,
    REG_TONE_GAIN   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [INDEX_W-1:0] sample_index;
    logic               end_of_run;
  } mix_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       end_of_run_out;
  } mix_out_t;

  // Entry k of the quarter-wave table: round(32767 * sin(pi/2 * k / 2^tbits)),
  // evaluated in Q30 with a nested Taylor series. Used at elaboration only.
  function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] u;
    logic [63:0] s;
    logic [63:0] e;
    x  = (64'(k) * 64'd1686629713) >> tbits;
    x2 = (x * x) >> 30;
    u  = 64'd1 << 30;
    u  = (64'd1 << 30) - (((x2 * u) >> 30) / 64'd156);
    u  = (64'd1 << 30) - (((x2 * u) >> 30) / 64'd110);
    u  = (64'd1 << 30) - (((x2 * u) >> 30) / 64'd72);
    u  = (64'd1 << 30) - (((x2 * u) >> 30) / 64'd42);
    u  = (64'd1 << 30) - (((x2 * u) >> 30) / 64'd20);
    u  = (64'd1 << 30) - (((x2 * u) >> 30) / 64'd6);
    s  = (x * u) >> 30;
    e  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (e > 64'd32767) begin
      e = 64'd32767;
    end
    return e[15:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/multi_tone_sine_mixer.sv
// Multi-tone sine mixer top level: configuration registers and the
// five-stage synthesis pipeline. Depends on mtsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A sample index is taken on every cycle in which start is high; busy is
// always low, so one sample per clock is sustained. The mixed sample appears
// on out_data_o with done_o high for one cycle, after it has passed through the
// pipeline, and the receiver cannot stall it. The five pipeline stages are the
// input register, the per-tone phase multiply, the sine table read, the gain
// multiply, and the mix with saturation. Configuration writes are always
// ready and must only be made while no sample is in flight.
module multi_tone_sine_mixer
  import mtsm_pkg::*;
#(
  parameter int unsigned MAX_TONES       = MAX_TONES_DEF,
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire mix_in_t               in_data_i,
  output logic                       done_o,
  output mix_out_t                   out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LANES      = (MAX_TONES < NUM_STEP_REGS) ? MAX_TONES : NUM_STEP_REGS;
  localparam int unsigned TB         = SINE_TABLE_BITS;
  localparam int unsigned QTAB_SIZE  = 1 << TB;
  localparam int unsigned ADDR_W     = TB + 1;
  localparam int unsigned PH_W       = TB + 2;
  localparam int unsigned PROD_W     = INDEX_W + STEP_W;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned SCALE_W    = MAG_W + GAIN_W;
  localparam int unsigned TONE_W     = 17;
  localparam int unsigned SUM_W      = 20;

  localparam logic signed [SUM_W-1:0] SAT_POS = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_NEG = -SUM_W'(32767);

  logic [COUNT_W-1:0] tone_count_q;
  logic [GAIN_W-1:0]  tone_gain_q;
  logic [STEP_W-1:0]  tone_step_q [LANES];

  logic [15:0] sine_rom [QTAB_SIZE+1];

  logic               s1_valid_q;
  logic               s1_eor_q;
  logic [INDEX_W-1:0] s1_idx_q;

  logic               s2_valid_q;
  logic               s2_eor_q;
  logic [PH_W-1:0]    ph_q [LANES];

  logic               s3_valid_q;
  logic               s3_eor_q;
  logic [MAG_W-1:0]   mag_q [LANES];
  logic               neg_q [LANES];
  logic               act_q [LANES];

  logic                     s4_valid_q;
  logic                     s4_eor_q;
  logic signed [TONE_W-1:0] tone_q [LANES];

  logic                     out_valid_q;
  mix_out_t                 out_q;
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SAMPLE_W-1:0] sat_d;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign done_o      = out_valid_q;
  assign out_data_o  = out_q;

  for (genvar k = 0; k <= QTAB_SIZE; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, TB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_count_q <= COUNT_RESET;
      tone_gain_q  <= GAIN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_TONE_COUNT: begin
          tone_count_q <= cfg_data_i[COUNT_W-1:0];
        end
        REG_TONE_GAIN: begin
          tone_gain_q <= cfg_data_i[GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar t = 0; t < LANES; t++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tone_step_q[t] <= '0;
      end else if (cfg_valid_i &&
                   cfg_addr_i == CFG_ADDR_W'(REG_TONE_STEP_0) + CFG_ADDR_W'(t)) begin
        tone_step_q[t] <= cfg_data_i[STEP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= start;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      s1_idx_q <= in_data_i.sample_index;
      s1_eor_q <= in_data_i.end_of_run;
    end
    s2_eor_q <= s1_eor_q;
    s3_eor_q <= s2_eor_q;
    s4_eor_q <= s3_eor_q;
  end

  for (genvar t = 0; t < LANES; t++) begin : g_lane
    logic [PROD_W-1:0]   prod;
    logic [ADDR_W-1:0]   addr;
    logic [SCALE_W-1:0]  scaled;
    logic [TONE_W-1:0]   mag_gain;

    assign prod     = PROD_W'(s1_idx_q) * PROD_W'(tone_step_q[t]);
    assign addr     = ph_q[t][TB] ? ADDR_W'(QTAB_SIZE) - ADDR_W'(ph_q[t][TB-1:0])
                                  : ADDR_W'(ph_q[t][TB-1:0]);
    assign scaled   = SCALE_W'(mag_q[t]) * SCALE_W'(tone_gain_q);
    assign mag_gain = TONE_W'(scaled[SCALE_W-1:15]);

    always_ff @(posedge clk_i) begin
      ph_q[t]  <= prod[PHASE_BITS-1 -: PH_W];
      mag_q[t] <= sine_rom[addr][MAG_W-1:0];
      neg_q[t] <= ph_q[t][TB+1];
      act_q[t] <= tone_count_q > COUNT_W'(t);
      if (!act_q[t]) begin
        tone_q[t] <= '0;
      end else if (neg_q[t]) begin
        tone_q[t] <= -$signed(mag_gain);
      end else begin
        tone_q[t] <= $signed(mag_gain);
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int t = 0; t < LANES; t++) begin
      sum_d = sum_d + SUM_W'(tone_q[t]);
    end
    if (sum_d > SAT_POS) begin
      sat_d = SAMPLE_W'(SAT_POS);
    end else if (sum_d < SAT_NEG) begin
      sat_d = SAMPLE_W'(SAT_NEG);
    end else begin
      sat_d = sum_d[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.mixed_sample   <= sat_d;
    out_q.end_of_run_out <= s4_eor_q;
  end

endmodule

`default_nettype wire
